// File: rtl/blw_pkg.sv
// Shared types, constants and codes for the bouncy lattice walker.
package blw_pkg;

	// Lattice geometry.
	localparam int GRID_SIZE = 1024;
	localparam int GRID_W = $clog2(GRID_SIZE);
	localparam int HALF = GRID_SIZE / 2;

	// Field widths.
	localparam int POS_W = 15;
	localparam int DIR_W = 2;
	localparam int MODE_W = 4;
	localparam int GAIN_W = 20;
	localparam int AXIS_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 20;

	// Saturation limits of a landing position, one bit wider than a position.
	localparam logic signed [POS_W:0] POS_MAX = (POS_W + 1)'((1 << (POS_W - 1)) - 1);
	localparam logic signed [POS_W:0] POS_MIN = -(POS_W + 1)'(1 << (POS_W - 1));

	// Arithmetic widths of the jump units. A walker inside the grid has
	// magnitude at most HALF, which fits in GRID_W bits.
	localparam int ABS_W = GRID_W;
	localparam int FRAC_W = 16;
	localparam int N2_W = 2 * ABS_W + 1;
	localparam int SQ_ROOT_W = (N2_W + 2 * FRAC_W + 1) / 2;
	localparam int SQ_IN_W = 2 * SQ_ROOT_W;
	localparam int DVD_W = ABS_W + FRAC_W;

	// Bounce modes.
	localparam logic [MODE_W-1:0] MODE_NONE = 4'd0;
	localparam logic [MODE_W-1:0] MODE_LINE = 4'd1;
	localparam logic [MODE_W-1:0] MODE_IDLA = 4'd2;
	localparam logic [MODE_W-1:0] MODE_SIGN = 4'd3;
	localparam logic [MODE_W-1:0] MODE_SIG2 = 4'd4;
	localparam logic [MODE_W-1:0] MODE_SOFT = 4'd5;
	localparam logic [MODE_W-1:0] MODE_SQRT = 4'd6;
	localparam logic [MODE_W-1:0] MODE_MAXI = 4'd7;
	localparam logic [MODE_W-1:0] MODE_DENT = 4'd8;
	localparam logic [MODE_W-1:0] MODE_OCTO = 4'd9;

	// Step directions.
	localparam logic [DIR_W-1:0] DIR_PX = 2'd0;
	localparam logic [DIR_W-1:0] DIR_PY = 2'd1;
	localparam logic [DIR_W-1:0] DIR_NX = 2'd2;
	localparam logic [DIR_W-1:0] DIR_NY = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_GAIN = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [MODE_W-1:0] RST_BOUNCE_MODE = MODE_SQRT;
	localparam logic [GAIN_W-1:0] RST_LINE_GAIN = 20'd6554;
	localparam logic [AXIS_W-1:0] RST_AXIS_GAIN = 4'd2;

	// Configuration as seen by the step engine.
	typedef struct packed {
		logic [MODE_W-1:0] bounce_mode;
		logic [GAIN_W-1:0] line_gain;
		logic [AXIS_W-1:0] axis_gain;
	} cfg_t;

	// Head of the step queue.
	typedef struct packed {
		logic             valid;
		logic [DIR_W-1:0] dir;
	} q_head_t;

endpackage

// File: rtl/blw_if.sv
// Channel interfaces: step input, result output and configuration write.
interface blw_in_if;
	logic                      valid;
	logic                      ready;
	logic [blw_pkg::DIR_W-1:0] random_dir;

	modport source(output valid, output random_dir, input ready);
	modport sink(input valid, input random_dir, output ready);
endinterface

interface blw_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [blw_pkg::POS_W-1:0] pos_x;
	logic signed [blw_pkg::POS_W-1:0] pos_y;
	logic                             was_occupied;
	logic                             done_res;

	modport source(output valid, output pos_x, output pos_y, output was_occupied,
		output done_res, input ready);
	modport sink(input valid, input pos_x, input pos_y, input was_occupied,
		input done_res, output ready);
endinterface

interface blw_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [blw_pkg::CFG_IDX_W-1:0]  index;
	logic [blw_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/bouncy_lattice_walker.sv
// Top level of the bouncy lattice walker: configuration registers and wiring.
// Each step item gives one result item. After reset the block sweeps all
// 1024 rows of its occupancy memory clear, one row per cycle, and takes no
// step item until that is done; configuration writes are taken at any time.
// A step on an occupied site or in the none, idla, sign, sig2, soft, maxi,
// dent and octo modes goes through the calc and apply states to the result
// register, line mode adds a line state (one registered multiply per axis),
// and sqrt mode runs two passes of the 27-step iterative root unit followed by a
// 26-step bit-serial divider that runs both axes at once. Steps are worked
// on one at a time because each reads and writes the occupancy row of the
// site the previous step landed on. A two-entry queue takes new items while
// a step is in progress, and a result waits in its register until taken.
module bouncy_lattice_walker (
	input  logic       clk,
	input  logic       arst_n,
	blw_in_if.sink     in_ch,
	blw_out_if.source  out_ch,
	blw_cfg_if.sink    cfg_ch
);

	blw_pkg::cfg_t    cfg_q;
	blw_pkg::q_head_t head;
	logic             pop;
	logic             clearing;
	logic             walk_over;

	// Configuration registers; writes to unknown indexes are dropped.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bounce_mode <= blw_pkg::RST_BOUNCE_MODE;
			cfg_q.line_gain <= blw_pkg::RST_LINE_GAIN;
			cfg_q.axis_gain <= blw_pkg::RST_AXIS_GAIN;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				blw_pkg::REG_BOUNCE_MODE:
					cfg_q.bounce_mode <= cfg_ch.data[blw_pkg::MODE_W-1:0];
				blw_pkg::REG_LINE_GAIN:
					cfg_q.line_gain <= cfg_ch.data[blw_pkg::GAIN_W-1:0];
				blw_pkg::REG_AXIS_GAIN:
					cfg_q.axis_gain <= cfg_ch.data[blw_pkg::AXIS_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	blw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.clearing (clearing),
		.pop      (pop),
		.head     (head)
	);

	blw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.pop       (pop),
		.clearing  (clearing),
		.walk_over (walk_over),
		.out_ch    (out_ch)
	);

	// Once the walker has left the grid it stays out until reset.
	a_over_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		walk_over |=> walk_over)
		else $error("walk over flag cleared without reset");

	// No item is taken while the occupancy memory is being cleared.
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_ch.ready)
		else $error("step item accepted during clearing sweep");

	// The engine only pops a queued item.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue popped while empty");

	// A result is never offered while the queue is being popped.
	a_pop_not_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !out_ch.valid)
		else $error("pop while a result is pending");

endmodule

// File: rtl/blw_front.sv
// Front end: accepts step items into a two-entry queue for the step engine.
module blw_front (
	input  logic              clk,
	input  logic              arst_n,
	blw_in_if.sink            in_ch,
	input  logic              clearing,
	input  logic              pop,
	output blw_pkg::q_head_t  head
);

	logic [blw_pkg::DIR_W-1:0] slot_q [2];
	logic                      wr_ptr_q;
	logic                      rd_ptr_q;
	logic [1:0]                cnt_q;
	logic                      push;

	// No item is taken while the occupancy memory is being cleared.
	assign in_ch.ready = (cnt_q != 2'd2) && !clearing;
	assign push = in_ch.valid && in_ch.ready;

	assign head.valid = (cnt_q != 2'd0);
	assign head.dir = slot_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_ch.random_dir;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/blw_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module blw_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [blw_pkg::SQ_IN_W-1:0]       radicand,
	output logic                              done,
	output logic [blw_pkg::SQ_ROOT_W-1:0]     root
);

	localparam int CNT_W = $clog2(blw_pkg::SQ_ROOT_W);
	localparam int REM_W = blw_pkg::SQ_ROOT_W + 2;

	logic [blw_pkg::SQ_IN_W-1:0]   rad_q;
	logic [REM_W-1:0]              rem_q;
	logic [blw_pkg::SQ_ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [REM_W+1:0]              rem_sh;
	logic [REM_W+1:0]              trial;
	logic                          fits;

	// One restoring step: bring down two radicand bits, try root*4+1.
	assign rem_sh = {rem_q, rad_q[blw_pkg::SQ_IN_W-1 -: 2]};
	assign trial = (REM_W + 2)'({root_q, 2'b01});
	assign fits = (rem_sh >= trial);

	assign done = done_q;
	assign root = root_q;

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q <= REM_W'(rem_sh - trial);
				root_q <= {root_q[blw_pkg::SQ_ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= REM_W'(rem_sh);
				root_q <= {root_q[blw_pkg::SQ_ROOT_W-2:0], 1'b0};
			end
		end
	end

	// Iteration count; done rises for one cycle once the root is final.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(blw_pkg::SQ_ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/blw_back.sv
// Step engine: occupancy memory, bounce rules and position update.
module blw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  blw_pkg::cfg_t     cfg,
	input  blw_pkg::q_head_t  head,
	output logic              pop,
	output logic              clearing,
	output logic              walk_over,
	blw_out_if.source         out_ch
);

	localparam int POS_W = blw_pkg::POS_W;
	localparam int ABS_W = blw_pkg::ABS_W;
	localparam int GRID_W = blw_pkg::GRID_W;
	localparam int RT_W = blw_pkg::SQ_ROOT_W;
	localparam int DVD_W = blw_pkg::DVD_W;
	localparam int DCNT_W = $clog2(DVD_W);
	localparam int PROD_W = blw_pkg::GAIN_W + ABS_W;
	localparam int TERM_W = PROD_W - blw_pkg::FRAC_W;
	localparam int AXIS_W_M = blw_pkg::AXIS_W + 1;

	typedef enum logic [10:0] {
		ST_CLEAR = 11'b000_0000_0001,
		ST_IDLE  = 11'b000_0000_0010,
		ST_CALC  = 11'b000_0000_0100,
		ST_LINE  = 11'b000_0000_1000,
		ST_SQA   = 11'b000_0001_0000,
		ST_SQAW  = 11'b000_0010_0000,
		ST_SQB   = 11'b000_0100_0000,
		ST_SQBW  = 11'b000_1000_0000,
		ST_DIV   = 11'b001_0000_0000,
		ST_APPLY = 11'b010_0000_0000,
		ST_OUT   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// Occupancy rows and walker state.
	logic [blw_pkg::GRID_SIZE-1:0] occ_mem [blw_pkg::GRID_SIZE];
	logic [blw_pkg::GRID_SIZE-1:0] row_q;
	logic [GRID_W-1:0]             clr_row_q;
	logic signed [POS_W-1:0]       x_q;
	logic signed [POS_W-1:0]       y_q;
	logic                          over_q;
	logic [blw_pkg::DIR_W-1:0]     dir_q;
	logic                          occ_q;
	logic signed [POS_W-1:0]       jx_q;
	logic signed [POS_W-1:0]       jy_q;

	// Multiplier, root and divider registers.
	logic [PROD_W-1:0]             prodx_q;
	logic [PROD_W-1:0]             prody_q;
	logic [blw_pkg::N2_W-1:0]      n2_q;
	logic [RT_W-1:0]               div_q;
	logic [DVD_W-1:0]              dvdx_q;
	logic [DVD_W-1:0]              dvdy_q;
	logic [RT_W-1:0]               remx_q;
	logic [RT_W-1:0]               remy_q;
	logic [DVD_W-1:0]              quox_q;
	logic [DVD_W-1:0]              quoy_q;
	logic [DCNT_W-1:0]             dcnt_q;

	// Output register.
	logic signed [POS_W-1:0]       out_x_q;
	logic signed [POS_W-1:0]       out_y_q;
	logic                          out_occ_q;
	logic                          out_done_q;

	// Combinational helpers.
	logic signed [POS_W-1:0]       xs_half;
	logic signed [POS_W-1:0]       ys_half;
	logic [GRID_W-1:0]             col;
	logic [GRID_W-1:0]             row;
	logic [ABS_W-1:0]              ax;
	logic [ABS_W-1:0]              ay;
	logic                          occ_bit;
	logic signed [POS_W-1:0]       jx_c;
	logic signed [POS_W-1:0]       jy_c;
	logic signed [POS_W:0]         sum_xy;
	logic signed [POS_W:0]         dif_xy;
	logic signed [POS_W:0]         adif_xy;
	logic [AXIS_W_M-1:0]           m_sig2;
	logic [TERM_W-1:0]             termx;
	logic [TERM_W-1:0]             termy;
	logic                          sq_start;
	logic [blw_pkg::SQ_IN_W-1:0]   sq_rad;
	logic                          sq_done;
	logic [RT_W-1:0]               sq_root;
	logic [RT_W:0]                 remx_sh;
	logic [RT_W:0]                 remy_sh;
	logic                          fitx;
	logic                          fity;
	logic [DVD_W-1:0]              quox_n;
	logic [DVD_W-1:0]              quoy_n;
	logic signed [POS_W:0]         nx;
	logic signed [POS_W:0]         ny;
	logic signed [POS_W-1:0]       nx_sat;
	logic signed [POS_W-1:0]       ny_sat;
	logic                          out_of_grid;
	logic                          rd_en;
	logic                          wr_en;
	logic [GRID_W-1:0]             wr_addr;
	logic [blw_pkg::GRID_SIZE-1:0] wr_data;

	// Minus sign of v times m.
	function automatic logic signed [POS_W-1:0] neg_sgn_mul(
		input logic signed [POS_W-1:0] v,
		input logic [AXIS_W_M-1:0]     m
	);
		logic signed [POS_W-1:0] mm;
		mm = POS_W'(m);
		if (v > 0) begin
			return -mm;
		end else if (v < 0) begin
			return mm;
		end else begin
			return '0;
		end
	endfunction

	// Site index and magnitudes of the current position.
	assign xs_half = x_q + POS_W'(blw_pkg::HALF);
	assign ys_half = y_q + POS_W'(blw_pkg::HALF);
	assign col = xs_half[GRID_W-1:0];
	assign row = ys_half[GRID_W-1:0];
	assign ax = x_q[POS_W-1] ? ABS_W'(-x_q) : x_q[ABS_W-1:0];
	assign ay = y_q[POS_W-1] ? ABS_W'(-y_q) : y_q[ABS_W-1:0];
	assign occ_bit = row_q[col];

	// Jumps that need no multiplier: occupied step and the simple rules.
	always_comb begin
		sum_xy = (POS_W + 1)'(x_q) + (POS_W + 1)'(y_q);
		dif_xy = (POS_W + 1)'(x_q) - (POS_W + 1)'(y_q);
		adif_xy = dif_xy[POS_W] ? -dif_xy : dif_xy;
		if (x_q * y_q < 0) begin
			m_sig2 = AXIS_W_M'(1);
		end else if (x_q == '0 || y_q == '0) begin
			m_sig2 = (cfg.axis_gain == '0) ? AXIS_W_M'(1) :
				AXIS_W_M'(1) + AXIS_W_M'((cfg.axis_gain - 1'b1) >> 1);
		end else begin
			m_sig2 = AXIS_W_M'(cfg.axis_gain);
		end
		jx_c = '0;
		jy_c = '0;
		if (occ_bit) begin
			case (dir_q)
				blw_pkg::DIR_PX: jx_c = POS_W'(1);
				blw_pkg::DIR_PY: jy_c = POS_W'(1);
				blw_pkg::DIR_NX: jx_c = -POS_W'(1);
				blw_pkg::DIR_NY: jy_c = -POS_W'(1);
				default: jx_c = '0;
			endcase
		end else begin
			case (cfg.bounce_mode)
				blw_pkg::MODE_IDLA: begin
					jx_c = -x_q;
					jy_c = -y_q;
				end
				blw_pkg::MODE_SIGN: begin
					jx_c = neg_sgn_mul(x_q, AXIS_W_M'(1));
					jy_c = neg_sgn_mul(y_q, AXIS_W_M'(1));
				end
				blw_pkg::MODE_SIG2: begin
					jx_c = neg_sgn_mul(x_q, m_sig2);
					jy_c = neg_sgn_mul(y_q, m_sig2);
				end
				blw_pkg::MODE_SOFT: begin
					if (!x_q[POS_W-1] && ((ABS_W + 1)'(ax) > {ay, 1'b0})) begin
						jx_c = neg_sgn_mul(x_q, AXIS_W_M'(cfg.axis_gain));
						jy_c = neg_sgn_mul(y_q, AXIS_W_M'(cfg.axis_gain));
					end else begin
						jx_c = neg_sgn_mul(x_q, AXIS_W_M'(1));
						jy_c = neg_sgn_mul(y_q, AXIS_W_M'(1));
					end
				end
				blw_pkg::MODE_MAXI: begin
					if (ax > ay) begin
						jx_c = neg_sgn_mul(x_q, AXIS_W_M'(1));
					end else begin
						jy_c = neg_sgn_mul(y_q, AXIS_W_M'(1));
					end
				end
				blw_pkg::MODE_DENT: begin
					if (sum_xy > (adif_xy <<< 1)) begin
						if (y_q > x_q) begin
							jx_c = -POS_W'(1);
						end else begin
							jy_c = -POS_W'(1);
						end
					end else if (ay > ax) begin
						jy_c = neg_sgn_mul(y_q, AXIS_W_M'(1));
					end else begin
						jx_c = neg_sgn_mul(x_q, AXIS_W_M'(1));
					end
				end
				blw_pkg::MODE_OCTO: begin
					if ((ABS_W + 1)'(ax) > {ay, 1'b0}) begin
						jx_c = neg_sgn_mul(x_q, AXIS_W_M'(2));
					end else if ((ABS_W + 1)'(ay) > {ax, 1'b0}) begin
						jy_c = neg_sgn_mul(y_q, AXIS_W_M'(2));
					end else begin
						jx_c = neg_sgn_mul(x_q, AXIS_W_M'(1));
						jy_c = neg_sgn_mul(y_q, AXIS_W_M'(1));
					end
				end
				default: begin
					jx_c = '0;
					jy_c = '0;
				end
			endcase
		end
	end

	// Line mode terms from the registered products.
	assign termx = prodx_q[PROD_W-1:blw_pkg::FRAC_W];
	assign termy = prody_q[PROD_W-1:blw_pkg::FRAC_W];

	// Root unit is shared by both roots of the sqrt rule.
	assign sq_start = (state_q == ST_SQA) || (state_q == ST_SQB);
	assign sq_rad = (state_q == ST_SQA) ?
		blw_pkg::SQ_IN_W'({n2_q, {(2 * blw_pkg::FRAC_W){1'b0}}}) :
		blw_pkg::SQ_IN_W'({(RT_W + 1)'(sq_root) + (RT_W + 1)'(1 << blw_pkg::FRAC_W),
			{blw_pkg::FRAC_W{1'b0}}});

	blw_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.done     (sq_done),
		.root     (sq_root)
	);

	// One restoring division step on each axis.
	assign remx_sh = {remx_q, dvdx_q[DVD_W-1]};
	assign remy_sh = {remy_q, dvdy_q[DVD_W-1]};
	assign fitx = (remx_sh >= (RT_W + 1)'(div_q));
	assign fity = (remy_sh >= (RT_W + 1)'(div_q));
	assign quox_n = {quox_q[DVD_W-2:0], fitx};
	assign quoy_n = {quoy_q[DVD_W-2:0], fity};

	// Landing position, saturated, and the grid test.
	always_comb begin
		nx = (POS_W + 1)'(x_q) + (POS_W + 1)'(jx_q);
		ny = (POS_W + 1)'(y_q) + (POS_W + 1)'(jy_q);
		if (nx > blw_pkg::POS_MAX) begin
			nx_sat = POS_W'(blw_pkg::POS_MAX);
		end else if (nx < blw_pkg::POS_MIN) begin
			nx_sat = POS_W'(blw_pkg::POS_MIN);
		end else begin
			nx_sat = POS_W'(nx);
		end
		if (ny > blw_pkg::POS_MAX) begin
			ny_sat = POS_W'(blw_pkg::POS_MAX);
		end else if (ny < blw_pkg::POS_MIN) begin
			ny_sat = POS_W'(blw_pkg::POS_MIN);
		end else begin
			ny_sat = POS_W'(ny);
		end
		out_of_grid = (nx_sat < -POS_W'(blw_pkg::HALF)) || (nx_sat >= POS_W'(blw_pkg::HALF)) ||
			(ny_sat < -POS_W'(blw_pkg::HALF)) || (ny_sat >= POS_W'(blw_pkg::HALF));
	end

	// Memory port control: row read for a new step, clearing sweep or marking the site left.
	assign rd_en = (state_q == ST_IDLE) && head.valid && !over_q;
	assign wr_en = (state_q == ST_CLEAR) || (state_q == ST_APPLY);
	assign wr_addr = (state_q == ST_CLEAR) ? clr_row_q : row;
	assign wr_data = (state_q == ST_CLEAR) ? '0 :
		(row_q | (blw_pkg::GRID_SIZE'(1) << col));

	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_q <= occ_mem[row];
		end
		if (wr_en) begin
			occ_mem[wr_addr] <= wr_data;
		end
	end

	assign pop = (state_q == ST_IDLE) && head.valid;
	assign clearing = (state_q == ST_CLEAR);
	assign walk_over = over_q;

	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.pos_x = out_x_q;
	assign out_ch.pos_y = out_y_q;
	assign out_ch.was_occupied = out_occ_q;
	assign out_ch.done_res = out_done_q;

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dir_q <= head.dir;
				out_x_q <= x_q;
				out_y_q <= y_q;
				out_occ_q <= 1'b0;
				out_done_q <= 1'b1;
			end
			ST_CALC: begin
				occ_q <= occ_bit;
				jx_q <= jx_c;
				jy_q <= jy_c;
				prodx_q <= PROD_W'(cfg.line_gain) * PROD_W'(ax);
				prody_q <= PROD_W'(cfg.line_gain) * PROD_W'(ay);
				n2_q <= blw_pkg::N2_W'(ax) * blw_pkg::N2_W'(ax) +
					blw_pkg::N2_W'(ay) * blw_pkg::N2_W'(ay);
			end
			ST_LINE: begin
				jx_q <= x_q[POS_W-1] ? POS_W'(termx) : -POS_W'(termx);
				jy_q <= y_q[POS_W-1] ? POS_W'(termy) : -POS_W'(termy);
			end
			ST_SQBW: begin
				div_q <= sq_root;
				dvdx_q <= {ax, {blw_pkg::FRAC_W{1'b0}}};
				dvdy_q <= {ay, {blw_pkg::FRAC_W{1'b0}}};
				remx_q <= '0;
				remy_q <= '0;
				quox_q <= '0;
				quoy_q <= '0;
			end
			ST_DIV: begin
				dvdx_q <= dvdx_q << 1;
				dvdy_q <= dvdy_q << 1;
				remx_q <= fitx ? RT_W'(remx_sh - (RT_W + 1)'(div_q)) : RT_W'(remx_sh);
				remy_q <= fity ? RT_W'(remy_sh - (RT_W + 1)'(div_q)) : RT_W'(remy_sh);
				quox_q <= quox_n;
				quoy_q <= quoy_n;
				jx_q <= x_q[POS_W-1] ? quox_n[POS_W-1:0] : -quox_n[POS_W-1:0];
				jy_q <= y_q[POS_W-1] ? quoy_n[POS_W-1:0] : -quoy_n[POS_W-1:0];
			end
			ST_APPLY: begin
				out_x_q <= nx_sat;
				out_y_q <= ny_sat;
				out_occ_q <= occ_q;
				out_done_q <= out_of_grid;
			end
			default: begin
				dir_q <= dir_q;
			end
		endcase
	end

	// Step sequencer and walker position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_row_q <= '0;
			x_q <= '0;
			y_q <= '0;
			over_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_row_q <= clr_row_q + 1'b1;
					if (clr_row_q == GRID_W'(blw_pkg::GRID_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						state_q <= over_q ? ST_OUT : ST_CALC;
					end
				end
				ST_CALC: begin
					if (occ_bit) begin
						state_q <= ST_APPLY;
					end else if (cfg.bounce_mode == blw_pkg::MODE_LINE) begin
						state_q <= ST_LINE;
					end else if (cfg.bounce_mode == blw_pkg::MODE_SQRT) begin
						state_q <= ST_SQA;
					end else begin
						state_q <= ST_APPLY;
					end
				end
				ST_LINE: state_q <= ST_APPLY;
				ST_SQA: state_q <= ST_SQAW;
				ST_SQAW: begin
					if (sq_done) begin
						state_q <= ST_SQB;
					end
				end
				ST_SQB: state_q <= ST_SQBW;
				ST_SQBW: begin
					dcnt_q <= '0;
					if (sq_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_W'(DVD_W - 1)) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					x_q <= nx_sat;
					y_q <= ny_sat;
					over_q <= out_of_grid;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench of the bouncy lattice walker: directed table, random phases.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int POS_W = blw_pkg::POS_W;
	localparam int DIR_W = blw_pkg::DIR_W;
	localparam int MODE_W = blw_pkg::MODE_W;
	localparam int GAIN_W = blw_pkg::GAIN_W;
	localparam int AXIS_W = blw_pkg::AXIS_W;
	localparam int CFG_IDX_W = blw_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = blw_pkg::CFG_DATA_W;
	localparam int GRID_SIZE = blw_pkg::GRID_SIZE;
	localparam int HALF = blw_pkg::HALF;
	localparam int LIM_MIN = int'(blw_pkg::POS_MIN);
	localparam int LIM_MAX = int'(blw_pkg::POS_MAX);

	typedef struct {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic                    was_occupied;
		logic                    done_res;
	} walk_res_t;

	typedef enum logic {ROW_STEP, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
		logic [DIR_W-1:0]      dir;
		bit                    typed;
		walk_res_t             res;
	} stim_row_t;

	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES = 160;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	blw_in_if  in_ch();
	blw_out_if out_ch();
	blw_cfg_if cfg_ch();

	bouncy_lattice_walker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	always #2 clk = ~clk;

	// Shadow state of the walker and its registers.
	bit                occ_map [0:GRID_SIZE*GRID_SIZE-1];
	int                walk_x, walk_y;
	bit                walk_ended;
	logic [MODE_W-1:0] sh_mode = blw_pkg::RST_BOUNCE_MODE;
	logic [GAIN_W-1:0] sh_gain = blw_pkg::RST_LINE_GAIN;
	logic [AXIS_W-1:0] sh_axis = blw_pkg::RST_AXIS_GAIN;

	walk_res_t pending_pos[$];
	int        fail_count = 0;
	int        steps_sent = 0;
	int        results_seen = 0;
	int        occupied_seen = 0;
	bit        quiet = 1'b0;
	bit        hold_req = 1'b0;
	bit        modes_hit [0:15];

	function automatic int sgn(int v);
		return (v > 0) - (v < 0);
	endfunction

	function automatic int mag(int v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Jump taken from an unoccupied site under the current bounce rule.
	function automatic void bounce_jump(input int x, input int y,
		output int jx, output int jy);
		int sx = sgn(x);
		int sy = sgn(y);
		int a = int'(sh_axis);
		int m;
		longint unsigned n2, s, q, t;
		jx = 0;
		jy = 0;
		case (sh_mode)
			blw_pkg::MODE_LINE: begin
				t = (longint'(sh_gain) * mag(x)) >> 16;
				jx = x < 0 ? int'(t) : -int'(t);
				t = (longint'(sh_gain) * mag(y)) >> 16;
				jy = y < 0 ? int'(t) : -int'(t);
			end
			blw_pkg::MODE_IDLA: begin
				jx = -x;
				jy = -y;
			end
			blw_pkg::MODE_SIGN: begin
				jx = -sx;
				jy = -sy;
			end
			blw_pkg::MODE_SIG2: begin
				m = 1 + (a - 1) * (1 + sx * sy) / 2;
				jx = -sx * m;
				jy = -sy * m;
			end
			blw_pkg::MODE_SOFT: begin
				m = (x > 2 * mag(y)) ? a : 1;
				jx = -sx * m;
				jy = -sy * m;
			end
			blw_pkg::MODE_SQRT: begin
				n2 = longint'(x) * x + longint'(y) * y;
				s = int_root(n2 << 32);
				q = int_root((64'd65536 + s) << 16);
				t = (longint'(mag(x)) << 16) / q;
				jx = x < 0 ? int'(t) : -int'(t);
				t = (longint'(mag(y)) << 16) / q;
				jy = y < 0 ? int'(t) : -int'(t);
			end
			blw_pkg::MODE_MAXI: begin
				if (mag(x) > mag(y)) jx = -sx;
				else jy = -sy;
			end
			blw_pkg::MODE_DENT: begin
				if (x + y > 2 * mag(x - y)) begin
					if (y > x) jx = -1;
					else jy = -1;
				end else begin
					if (mag(y) > mag(x)) jy = -sy;
					else jx = -sx;
				end
			end
			blw_pkg::MODE_OCTO: begin
				if (mag(x) > 2 * mag(y)) jx = -2 * sx;
				else if (mag(y) > 2 * mag(x)) jy = -2 * sy;
				else begin
					jx = -sx;
					jy = -sy;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int clamp_pos(int v);
		return v < LIM_MIN ? LIM_MIN : (v > LIM_MAX ? LIM_MAX : v);
	endfunction

	function automatic bit on_grid(int c);
		return c + HALF >= 0 && c + HALF < GRID_SIZE;
	endfunction

	// Advance the shadow walker by one step and return the position it reports.
	function automatic walk_res_t walk_step(logic [DIR_W-1:0] dir);
		walk_res_t r;
		int idx, jx, jy;
		bit occ = 1'b0;
		if (!walk_ended) begin
			idx = (walk_y + HALF) * GRID_SIZE + (walk_x + HALF);
			occ = occ_map[idx];
			if (occ) begin
				case (dir)
					blw_pkg::DIR_PX: begin jx = 1; jy = 0; end
					blw_pkg::DIR_PY: begin jx = 0; jy = 1; end
					blw_pkg::DIR_NX: begin jx = -1; jy = 0; end
					default: begin jx = 0; jy = -1; end
				endcase
			end else begin
				bounce_jump(walk_x, walk_y, jx, jy);
				modes_hit[sh_mode] = 1'b1;
			end
			occ_map[idx] = 1'b1;
			walk_x = clamp_pos(walk_x + jx);
			walk_y = clamp_pos(walk_y + jy);
			if (!on_grid(walk_x) || !on_grid(walk_y)) walk_ended = 1'b1;
		end
		r.pos_x = POS_W'(walk_x);
		r.pos_y = POS_W'(walk_y);
		r.was_occupied = occ;
		r.done_res = walk_ended;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Scoreboard: each taken result item against the oldest expectation.
	always @(posedge clk) begin
		walk_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (pending_pos.size() == 0) begin
				report_mismatch("result count", results_seen, steps_sent);
			end else begin
				want = pending_pos.pop_front();
				if (out_ch.pos_x !== want.pos_x)
					report_mismatch("pos_x", out_ch.pos_x, want.pos_x);
				if (out_ch.pos_y !== want.pos_y)
					report_mismatch("pos_y", out_ch.pos_y, want.pos_y);
				if (out_ch.was_occupied !== want.was_occupied)
					report_mismatch("was_occupied", out_ch.was_occupied, want.was_occupied);
				if (out_ch.done_res !== want.done_res)
					report_mismatch("done_res", out_ch.done_res, want.done_res);
			end
		end
	end

	// Receiver: random stall bursts, one long hold-off on request, none when quiet.
	initial begin
		int n;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
				hold_req = 1'b0;
				out_ch.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end
		end
	end

	// Offer one step item and hold it until taken; valid stays high afterwards.
	task automatic send_step(logic [DIR_W-1:0] dir, bit typed, walk_res_t typed_res);
		walk_res_t r;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.random_dir <= dir;
		do @(posedge clk); while (!in_ch.ready);
		r = walk_step(dir);
		if (r.was_occupied) occupied_seen++;
		pending_pos.push_back(typed ? typed_res : r);
		steps_sent++;
	endtask

	task automatic pause_sender(int cycles);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Wait until every result is in, then let any step still in flight finish.
	task automatic drain_walker();
		pause_sender(1);
		wait (pending_pos.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		drain_walker();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (index)
			blw_pkg::REG_BOUNCE_MODE: sh_mode = data[MODE_W-1:0];
			blw_pkg::REG_LINE_GAIN: sh_gain = data[GAIN_W-1:0];
			blw_pkg::REG_AXIS_GAIN: sh_axis = data[AXIS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_step();
		walk_res_t none_res;
		if (!quiet && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 18));
		send_step(DIR_W'($urandom_range(0, 3)), 1'b0, none_res);
	endtask

	stim_row_t plan[$];

	function automatic stim_row_t step_row(logic [DIR_W-1:0] dir);
		stim_row_t r;
		r.kind = ROW_STEP;
		r.index = '0;
		r.data = '0;
		r.dir = dir;
		r.typed = 1'b0;
		r.res = '{default: '0};
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] index,
		logic [CFG_DATA_W-1:0] data);
		stim_row_t r = step_row(blw_pkg::DIR_PX);
		r.kind = ROW_CFG;
		r.index = index;
		r.data = data;
		return r;
	endfunction

	// Main stimulus.
	initial begin
		stim_row_t row;
		int phase, k;
		in_ch.valid = 1'b0;
		in_ch.random_dir = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		walk_x = 0;
		walk_y = 0;
		walk_ended = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table. The first two rows are known after reset: sqrt mode
		// leaves the centre in place, then the occupied centre steps to +x.
		row = step_row(blw_pkg::DIR_PX);
		row.typed = 1'b1;
		row.res = '{pos_x: 0, pos_y: 0, was_occupied: 1'b0, done_res: 1'b0};
		plan.push_back(row);
		row.res = '{pos_x: 1, pos_y: 0, was_occupied: 1'b1, done_res: 1'b0};
		plan.push_back(row);
		plan.push_back(step_row(blw_pkg::DIR_PY));
		// A write to an index past the last register is dropped.
		plan.push_back(cfg_row(2'd3, 20'hFFFFF));
		plan.push_back(step_row(blw_pkg::DIR_NX));
		plan.push_back(cfg_row(blw_pkg::REG_BOUNCE_MODE, 20'hFFFF0));
		plan.push_back(step_row(blw_pkg::DIR_NY));
		plan.push_back(step_row(blw_pkg::DIR_NY));
		plan.push_back(cfg_row(blw_pkg::REG_BOUNCE_MODE, 20'(blw_pkg::MODE_IDLA)));
		plan.push_back(step_row(blw_pkg::DIR_PX));
		plan.push_back(step_row(blw_pkg::DIR_PY));
		plan.push_back(cfg_row(blw_pkg::REG_BOUNCE_MODE, 20'hF));
		plan.push_back(step_row(blw_pkg::DIR_NX));
		plan.push_back(cfg_row(blw_pkg::REG_AXIS_GAIN, 20'hF));
		plan.push_back(cfg_row(blw_pkg::REG_BOUNCE_MODE, 20'(blw_pkg::MODE_SIG2)));
		plan.push_back(step_row(blw_pkg::DIR_NY));
		plan.push_back(step_row(blw_pkg::DIR_PX));
		plan.push_back(cfg_row(blw_pkg::REG_BOUNCE_MODE, 20'(blw_pkg::MODE_SOFT)));
		plan.push_back(step_row(blw_pkg::DIR_PX));
		plan.push_back(cfg_row(blw_pkg::REG_LINE_GAIN, 20'h1FFFF));
		plan.push_back(cfg_row(blw_pkg::REG_BOUNCE_MODE, 20'(blw_pkg::MODE_LINE)));
		plan.push_back(step_row(blw_pkg::DIR_PY));
		plan.push_back(cfg_row(blw_pkg::REG_AXIS_GAIN, 20'h0));
		plan.push_back(cfg_row(blw_pkg::REG_BOUNCE_MODE, 20'(blw_pkg::MODE_SIG2)));
		plan.push_back(step_row(blw_pkg::DIR_NX));
		plan.push_back(cfg_row(blw_pkg::REG_BOUNCE_MODE, 20'(blw_pkg::MODE_MAXI)));
		plan.push_back(step_row(blw_pkg::DIR_NY));
		plan.push_back(cfg_row(blw_pkg::REG_BOUNCE_MODE, 20'(blw_pkg::MODE_DENT)));
		plan.push_back(step_row(blw_pkg::DIR_PX));
		plan.push_back(cfg_row(blw_pkg::REG_BOUNCE_MODE, 20'(blw_pkg::MODE_OCTO)));
		plan.push_back(step_row(blw_pkg::DIR_PY));
		plan.push_back(cfg_row(blw_pkg::REG_BOUNCE_MODE, 20'(blw_pkg::MODE_SIGN)));
		plan.push_back(step_row(blw_pkg::DIR_NX));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) write_reg(plan[i].index, plan[i].data);
			else send_step(plan[i].dir, plan[i].typed, plan[i].res);
		end

		// Random phases, each under a fresh setting. Gains below two keep the
		// walker on the grid so the walk lasts the whole run.
		for (phase = 0; phase < 11; phase++) begin
			write_reg(blw_pkg::REG_BOUNCE_MODE,
				20'($urandom_range(0, 15)) | (20'($urandom) << MODE_W));
			write_reg(blw_pkg::REG_LINE_GAIN, 20'($urandom_range(0, 20'h1FFFF)));
			write_reg(blw_pkg::REG_AXIS_GAIN, 20'($urandom_range(0, 15)));
			if (phase == 3) hold_req = 1'b1;
			for (k = 0; k < 46; k++) random_step();
		end

		// Closing phase, no idling: a huge line gain throws the walker off the
		// grid, then a few steps after the walk is over.
		quiet = 1'b1;
		write_reg(blw_pkg::REG_BOUNCE_MODE, 20'(blw_pkg::MODE_LINE));
		write_reg(blw_pkg::REG_LINE_GAIN, 20'hFFFFF);
		for (k = 0; k < 200 && !walk_ended; k++) random_step();
		for (k = 0; k < 8; k++) random_step();

		drain_walker();
		$display("Run covered %0d step items, %0d results, %0d on occupied sites.",
			steps_sent, results_seen, occupied_seen);
		$display({"Bounce rules exercised: none %0b line %0b idla %0b sign %0b sig2 %0b",
			" soft %0b sqrt %0b maxi %0b dent %0b octo %0b, walk ended %0b."},
			modes_hit[0], modes_hit[1], modes_hit[2], modes_hit[3], modes_hit[4],
			modes_hit[5], modes_hit[6], modes_hit[7], modes_hit[8], modes_hit[9],
			walk_ended);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog on the whole run.
	initial begin
		#2400000;
		$display("FAILURE");
		$finish;
	end
endmodule
